// ===== design/tirc_pkg.sv =====
// tirc_pkg: shared types and constants for the tensor index run compressor
// transfer payloads, sequencer phases and the order tracker's status struct
// no dependencies
package tirc_pkg;

	localparam int AXES    = 4;
	localparam int IDX_W   = 8;
	localparam int ADDR_W  = 16;
	localparam int VAL_W   = 9;
	localparam int AXIS_W  = 2;

	localparam logic [VAL_W-1:0] COUNT_MAX = 9'd511;

	typedef struct packed {
		logic [IDX_W-1:0] index_0;
		logic [IDX_W-1:0] index_1;
		logic [IDX_W-1:0] index_2;
		logic [IDX_W-1:0] index_3;
		logic             final_tuple;
	} in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] write_address;
		logic [VAL_W-1:0]  write_value;
		logic [IDX_W-1:0]  shape_0;
		logic [IDX_W-1:0]  shape_1;
		logic [IDX_W-1:0]  shape_2;
		logic [IDX_W-1:0]  shape_3;
		logic              run_end;
		logic              order_error;
	} out_t;

	typedef enum logic [2:0] {
		PH_OPEN_CNT,
		PH_OPEN_IDX,
		PH_FLIP,
		PH_PATCH,
		PH_FINAL
	} phase_t;

	typedef struct packed {
		logic                        first;
		logic                        err;
		logic [AXIS_W-1:0]           flip;
		logic [AXES-1:0][IDX_W-1:0]  shape;
	} track_t;

endpackage

// ===== design/tirc_track.sv =====
// tirc_track: order check, flip axis search and running shape for each tuple
// holds the previous tuple, sequence flag and shape maxima
// depends on tirc_pkg
module tirc_track #(
	parameter int DIMS = 3
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        load,
	input  logic [tirc_pkg::AXES-1:0][tirc_pkg::IDX_W-1:0] idx,
	input  logic                                        final_tuple,
	output tirc_pkg::track_t                            info
);

	localparam logic [tirc_pkg::AXIS_W-1:0] LAST_AXIS = tirc_pkg::AXIS_W'(DIMS - 1);

	logic [tirc_pkg::AXES-1:0][tirc_pkg::IDX_W-1:0] prev_q;
	logic [tirc_pkg::AXES-1:0][tirc_pkg::IDX_W-1:0] shape_q;
	logic                                           in_seq_q;

	always_comb begin
		logic found;
		logic err;
		logic [tirc_pkg::AXIS_W-1:0] flip;
		found = 1'b0;
		err   = 1'b0;
		flip  = LAST_AXIS;
		for (int a = 0; a < tirc_pkg::AXES - 1; a++) begin
			if (a + 1 < DIMS && !found) begin
				if (idx[a] > prev_q[a]) begin
					flip  = tirc_pkg::AXIS_W'(a);
					found = 1'b1;
				end else if (idx[a] != prev_q[a]) begin
					err = 1'b1;
				end
			end
		end
		if (!found && idx[LAST_AXIS] <= prev_q[LAST_AXIS]) begin
			err = 1'b1;
		end
		info.first = !in_seq_q;
		info.err   = in_seq_q & err;
		info.flip  = flip;
		for (int a = 0; a < tirc_pkg::AXES; a++) begin
			if (a >= DIMS || !in_seq_q) begin
				info.shape[a] = tirc_pkg::IDX_W'(1);
			end else if (idx[a] > shape_q[a]) begin
				info.shape[a] = idx[a];
			end else begin
				info.shape[a] = shape_q[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_seq_q <= 1'b0;
			for (int a = 0; a < tirc_pkg::AXES; a++) begin
				prev_q[a]  <= '0;
				shape_q[a] <= tirc_pkg::IDX_W'(1);
			end
		end else if (load) begin
			in_seq_q <= !final_tuple;
			prev_q   <= idx;
			shape_q  <= info.shape;
		end
	end

endmodule

// ===== design/tensor_index_run_compressor.sv =====
// tensor_index_run_compressor: top level, write sequencer and result register
// turns c-ordered index tuples into run-length tree memory writes
// depends on tirc_pkg and tirc_track
//
// usage
//   in channel (in_valid / in_ready / in_data) takes one index tuple per transfer;
//   final_tuple closes the current sequence
//   out channel (out_valid / out_ready / out_data) gives one memory write per
//   transfer, address, value, shape on writes of a final tuple, run_end on the
//   last write of a final tuple and order_error on every write of a bad tuple
// timing
//   a tuple is held in one stage register while a sequencer emits its writes,
//   one per cycle into the result register while the receiver does not stall
//   the stage register takes the tuple, then the result register its first write
//   a tuple makes one write per sequencer step: one for an innermost
//   step, up to 4*DIMS-2 for a flip at axis 0 with final_tuple set, 3*DIMS
//   for a single-tuple sequence; the next tuple is taken in the cycle the
//   last write leaves the stage
// reset
//   write pointer to zero, waiting for the first tuple, counts and shape to one
// stall
//   a stalled receiver holds the result register; the sequencer stalls with it,
//   the input too once the stage holds a tuple, and nothing is lost
module tensor_index_run_compressor #(
	parameter int DIMS         = 3,
	parameter int ADDRESS_BITS = 16,
	parameter int INDEX_BITS   = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tirc_pkg::in_t    in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output tirc_pkg::out_t   out_data
);

	localparam int AW       = ADDRESS_BITS;
	localparam int IDX_KEEP = (INDEX_BITS < tirc_pkg::IDX_W) ? INDEX_BITS : tirc_pkg::IDX_W;
	localparam logic [tirc_pkg::IDX_W-1:0] IDX_MASK =
		tirc_pkg::IDX_W'((64'd1 << IDX_KEEP) - 64'd1);
	localparam logic [tirc_pkg::AXIS_W-1:0] LAST_AXIS = tirc_pkg::AXIS_W'(DIMS - 1);

	logic [tirc_pkg::AXES-1:0][tirc_pkg::IDX_W-1:0] idx_in;
	tirc_pkg::track_t track;
	logic             accept;

	logic                                           valid_s1;
	logic [tirc_pkg::AXES-1:0][tirc_pkg::IDX_W-1:0] idx_s1;
	logic                                           final_s1;
	tirc_pkg::track_t                               track_s1;

	tirc_pkg::phase_t                 phase_q;
	tirc_pkg::phase_t                 phase_next;
	logic [tirc_pkg::AXIS_W-1:0]      axis_q;
	logic [tirc_pkg::AXIS_W-1:0]      axis_next;
	logic                             done;

	logic [AW-1:0]                    wp_q;
	logic [AW-1:0]                    slot_q [tirc_pkg::AXES];
	logic [tirc_pkg::VAL_W-1:0]       count_q [tirc_pkg::AXES];

	logic [AW-1:0]                    wr_addr;
	logic [AW+tirc_pkg::ADDR_W-1:0]   wr_addr_ext;
	logic [tirc_pkg::VAL_W-1:0]       wr_val;
	logic                             use_ptr;
	logic                             emit;
	logic                             item_done;

	logic                             out_valid_q;
	tirc_pkg::out_t                   out_q;

	assign idx_in[0] = in_data.index_0 & IDX_MASK;
	assign idx_in[1] = in_data.index_1 & IDX_MASK;
	assign idx_in[2] = in_data.index_2 & IDX_MASK;
	assign idx_in[3] = in_data.index_3 & IDX_MASK;

	assign emit      = valid_s1 && (!out_valid_q || out_ready);
	assign item_done = emit && done;
	assign in_ready  = !valid_s1 || item_done;
	assign accept    = in_valid && in_ready;

	tirc_track #(
		.DIMS(DIMS)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.idx         (idx_in),
		.final_tuple (in_data.final_tuple),
		.info        (track)
	);

	// next phase
	always_comb begin
		phase_next = phase_q;
		axis_next  = axis_q;
		done       = 1'b0;
		case (phase_q)
			tirc_pkg::PH_OPEN_CNT: begin
				phase_next = tirc_pkg::PH_OPEN_IDX;
			end
			tirc_pkg::PH_OPEN_IDX: begin
				if (axis_q < LAST_AXIS) begin
					phase_next = track_s1.first ? tirc_pkg::PH_OPEN_CNT : tirc_pkg::PH_PATCH;
					axis_next  = axis_q + 1'b1;
				end else if (final_s1) begin
					phase_next = tirc_pkg::PH_FINAL;
					axis_next  = '0;
				end else begin
					done = 1'b1;
				end
			end
			tirc_pkg::PH_FLIP: begin
				if (track_s1.flip < LAST_AXIS) begin
					phase_next = tirc_pkg::PH_PATCH;
					axis_next  = track_s1.flip + 1'b1;
				end else if (final_s1) begin
					phase_next = tirc_pkg::PH_FINAL;
					axis_next  = '0;
				end else begin
					done = 1'b1;
				end
			end
			tirc_pkg::PH_PATCH: begin
				phase_next = tirc_pkg::PH_OPEN_CNT;
			end
			tirc_pkg::PH_FINAL: begin
				if (axis_q < LAST_AXIS) begin
					axis_next = axis_q + 1'b1;
				end else begin
					done = 1'b1;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	// write for the current phase
	always_comb begin
		wr_addr = wp_q;
		wr_val  = '0;
		use_ptr = 1'b1;
		case (phase_q)
			tirc_pkg::PH_OPEN_CNT: begin
				wr_val = '0;
			end
			tirc_pkg::PH_OPEN_IDX: begin
				wr_val = {1'b0, idx_s1[axis_q]};
			end
			tirc_pkg::PH_FLIP: begin
				wr_val = {1'b0, idx_s1[track_s1.flip]};
			end
			tirc_pkg::PH_PATCH, tirc_pkg::PH_FINAL: begin
				wr_addr = slot_q[axis_q];
				wr_val  = count_q[axis_q];
				use_ptr = 1'b0;
			end
			default: begin
				use_ptr = 1'b0;
			end
		endcase
	end

	assign wr_addr_ext = {{tirc_pkg::ADDR_W{1'b0}}, wr_addr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= tirc_pkg::PH_FLIP;
			axis_q   <= '0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			phase_q  <= track.first ? tirc_pkg::PH_OPEN_CNT : tirc_pkg::PH_FLIP;
			axis_q   <= '0;
		end else if (item_done) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			phase_q <= phase_next;
			axis_q  <= axis_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= idx_in;
			final_s1 <= in_data.final_tuple;
			track_s1 <= track;
		end
	end

	// pointer and run counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			for (int a = 0; a < tirc_pkg::AXES; a++) begin
				count_q[a] <= tirc_pkg::VAL_W'(1);
			end
		end else if (emit) begin
			if (use_ptr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (phase_q == tirc_pkg::PH_OPEN_CNT) begin
				count_q[axis_q] <= tirc_pkg::VAL_W'(1);
			end
			if (phase_q == tirc_pkg::PH_FLIP && count_q[track_s1.flip] != tirc_pkg::COUNT_MAX) begin
				count_q[track_s1.flip] <= count_q[track_s1.flip] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit && phase_q == tirc_pkg::PH_OPEN_CNT) begin
			slot_q[axis_q] <= wp_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.write_address <= wr_addr_ext[tirc_pkg::ADDR_W-1:0];
			out_q.write_value   <= wr_val;
			out_q.shape_0       <= final_s1 ? track_s1.shape[0] : '0;
			out_q.shape_1       <= final_s1 ? track_s1.shape[1] : '0;
			out_q.shape_2       <= final_s1 ? track_s1.shape[2] : '0;
			out_q.shape_3       <= final_s1 ? track_s1.shape[3] : '0;
			out_q.run_end       <= done && final_s1;
			out_q.order_error   <= track_s1.err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== verif/tirc_write_checker.sv =====
`timescale 1ns / 1ps
// tirc_write_checker: works out the memory writes of the tensor index run compressor
// from every accepted tuple and compares each write transfer, field by field
// depends on tirc_pkg
module tirc_write_checker #(
	parameter int DIMS = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  tirc_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  tirc_pkg::out_t out_data,
	output int             mismatches,
	output int             writes_pending
);

	localparam int MAX_WR = 16;

	logic [tirc_pkg::ADDR_W-1:0] wr_ptr;
	bit                          in_seq;
	logic [tirc_pkg::IDX_W-1:0]  last_idx [tirc_pkg::AXES];
	logic [tirc_pkg::ADDR_W-1:0] count_slot [tirc_pkg::AXES];
	logic [tirc_pkg::VAL_W-1:0]  run_len [tirc_pkg::AXES];
	logic [tirc_pkg::IDX_W-1:0]  extent [tirc_pkg::AXES];

	logic [tirc_pkg::ADDR_W-1:0] batch_addr [MAX_WR];
	logic [tirc_pkg::VAL_W-1:0]  batch_val [MAX_WR];
	int                          batch_n;

	tirc_pkg::out_t expected_writes [$];
	int             fails = 0;

	task automatic stage_write(input logic [tirc_pkg::ADDR_W-1:0] addr,
		input logic [tirc_pkg::VAL_W-1:0] val);
		batch_addr[batch_n] = addr;
		batch_val[batch_n] = val;
		batch_n++;
	endtask

	task automatic open_run(input int axis, input logic [tirc_pkg::IDX_W-1:0] idx);
		count_slot[axis] = wr_ptr;
		run_len[axis] = tirc_pkg::VAL_W'(1);
		stage_write(wr_ptr, '0);
		wr_ptr++;
		stage_write(wr_ptr, {1'b0, idx});
		wr_ptr++;
	endtask

	task automatic predict_writes(input tirc_pkg::in_t t);
		logic [tirc_pkg::IDX_W-1:0] idx [tirc_pkg::AXES];
		int                         flip;
		bit                         found;
		bit                         bad;
		bit                         last;
		tirc_pkg::out_t             w;
		idx[0] = t.index_0;
		idx[1] = t.index_1;
		idx[2] = t.index_2;
		idx[3] = t.index_3;
		last = t.final_tuple;
		bad = 0;
		batch_n = 0;
		if (!in_seq) begin
			for (int a = 0; a < DIMS; a++) begin
				extent[a] = tirc_pkg::IDX_W'(1);
				open_run(a, idx[a]);
			end
		end else begin
			flip = DIMS - 1;
			found = 0;
			for (int a = 0; a < DIMS - 1 && !found; a++) begin
				if (idx[a] > last_idx[a]) begin
					flip = a;
					found = 1;
				end else if (idx[a] != last_idx[a]) begin
					bad = 1;
				end
			end
			if (!found && idx[DIMS-1] <= last_idx[DIMS-1])
				bad = 1;
			if (run_len[flip] != tirc_pkg::COUNT_MAX)
				run_len[flip]++;
			stage_write(wr_ptr, {1'b0, idx[flip]});
			wr_ptr++;
			for (int a = flip + 1; a < DIMS; a++) begin
				stage_write(count_slot[a], run_len[a]);
				open_run(a, idx[a]);
			end
			for (int a = 0; a < DIMS; a++)
				if (idx[a] > extent[a])
					extent[a] = idx[a];
		end
		for (int a = 0; a < DIMS; a++)
			last_idx[a] = idx[a];
		if (last)
			for (int a = 0; a < DIMS; a++)
				stage_write(count_slot[a], run_len[a]);
		in_seq = !last;
		for (int k = 0; k < batch_n; k++) begin
			w = '0;
			w.write_address = batch_addr[k];
			w.write_value = batch_val[k];
			if (last) begin
				w.shape_0 = extent[0];
				w.shape_1 = extent[1];
				w.shape_2 = extent[2];
				w.shape_3 = extent[3];
			end
			w.run_end = last && k == batch_n - 1;
			w.order_error = bad;
			expected_writes = {expected_writes, w};
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			fails++;
		end
	endtask

	task automatic check_write(input tirc_pkg::out_t got);
		tirc_pkg::out_t want;
		if (expected_writes.size() == 0) begin
			$error("write transfer with nothing expected: address %0d value %0d",
				got.write_address, got.write_value);
			fails++;
		end else begin
			want = expected_writes.pop_front();
			check_field("write_address", 32'(want.write_address), 32'(got.write_address));
			check_field("write_value", 32'(want.write_value), 32'(got.write_value));
			check_field("shape_0", 32'(want.shape_0), 32'(got.shape_0));
			check_field("shape_1", 32'(want.shape_1), 32'(got.shape_1));
			check_field("shape_2", 32'(want.shape_2), 32'(got.shape_2));
			check_field("shape_3", 32'(want.shape_3), 32'(got.shape_3));
			check_field("run_end", 32'(want.run_end), 32'(got.run_end));
			check_field("order_error", 32'(want.order_error), 32'(got.order_error));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			wr_ptr = '0;
			in_seq = 0;
			for (int a = 0; a < tirc_pkg::AXES; a++) begin
				last_idx[a] = '0;
				count_slot[a] = '0;
				run_len[a] = tirc_pkg::VAL_W'(1);
				extent[a] = tirc_pkg::IDX_W'(1);
			end
			expected_writes.delete();
		end else begin
			if (in_valid && in_ready)
				predict_writes(in_data);
			if (out_valid && out_ready)
				check_write(out_data);
		end
		mismatches <= fails;
		writes_pending <= expected_writes.size();
	end

endmodule

// ===== verif/tensor_index_run_compressor_tb.sv =====
`timescale 1ns / 1ps
// tensor_index_run_compressor_tb: feeds ordered, broken and random index tuple
// sequences with random gaps and receiver stalls; tirc_write_checker judges the writes
// depends on tirc_pkg, tirc_write_checker and tensor_index_run_compressor
module tensor_index_run_compressor_tb;

	localparam int DIMS          = 3;
	localparam int CLK_PERIOD    = 12;
	localparam int RANDOM_TUPLES = 220;
	localparam int HOLD_CYCLES   = 80;

	typedef logic [tirc_pkg::AXES-1:0][tirc_pkg::IDX_W-1:0] axes_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid;
	logic           in_ready;
	tirc_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	tirc_pkg::out_t out_data;
	int             mismatches;
	int             writes_pending;

	bit tx_idle = 0;
	bit rx_idle = 0;
	int holds_asked = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	tensor_index_run_compressor #(
		.DIMS(DIMS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	tirc_write_checker #(
		.DIMS(DIMS)
	) write_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.mismatches(mismatches),
		.writes_pending(writes_pending)
	);

	task automatic send_tuple(input logic [tirc_pkg::IDX_W-1:0] i0, i1, i2, i3, input bit last);
		int            gap;
		tirc_pkg::in_t t;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		t.index_0 = i0;
		t.index_1 = i1;
		t.index_2 = i2;
		t.index_3 = i3;
		t.final_tuple = last;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (writes_pending != 0);
	endtask

	function automatic axes_t fresh_tuple();
		axes_t n;
		for (int a = 0; a < tirc_pkg::AXES; a++)
			n[a] = tirc_pkg::IDX_W'($urandom_range(0, 1) ?
				$urandom_range(0, 3) : $urandom_range(0, 255));
		return n;
	endfunction

	function automatic axes_t next_tuple(input axes_t p);
		axes_t n;
		int    roll;
		int    axis;
		int    room;
		n = p;
		n[3] = tirc_pkg::IDX_W'($urandom_range(0, 255));
		roll = $urandom_range(0, 99);
		if (roll < 6)
			return fresh_tuple();
		if (roll < 10)
			return n;
		if (roll < 14) begin
			axis = $urandom_range(0, DIMS - 1);
			if (p[axis] > 0)
				n[axis] = tirc_pkg::IDX_W'($urandom_range(0, p[axis] - 1));
			return n;
		end
		roll = $urandom_range(0, 9);
		axis = roll < 7 ? DIMS - 1 : (roll < 9 ? DIMS - 2 : 0);
		while (axis > 0 && p[axis] == 8'hFF)
			axis--;
		if (p[axis] == 8'hFF)
			return fresh_tuple();
		room = 255 - p[axis];
		if ($urandom_range(0, 9) == 0)
			n[axis] = tirc_pkg::IDX_W'(p[axis] + $urandom_range(1, room));
		else
			n[axis] = tirc_pkg::IDX_W'(p[axis] + $urandom_range(1, room < 3 ? room : 3));
		for (int a = axis + 1; a < DIMS; a++)
			n[a] = tirc_pkg::IDX_W'($urandom_range(0, 4) == 0 ?
				$urandom_range(0, 255) : $urandom_range(0, 3));
		return n;
	endfunction

	task automatic send_sequence(input int len);
		axes_t t;
		t = fresh_tuple();
		for (int k = 0; k < len; k++) begin
			if (k > 0)
				t = next_tuple(t);
			send_tuple(t[0], t[1], t[2], t[3], k == len - 1);
		end
	endtask

	initial begin
		int stall;
		int holds_done;
		holds_done = 0;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 6) : 0;
			if (holds_done < holds_asked) begin
				stall = HOLD_CYCLES;
				holds_done++;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		int sent;
		int seq_no;
		int len;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 1;
		rx_idle = 1;
		// lone tuples at both extremes
		send_tuple(8'h00, 8'h00, 8'h00, 8'h00, 1);
		send_tuple(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1);
		// flips at every axis, repeat, step back, then axis 0 flip on the last tuple
		send_tuple(8'h00, 8'h00, 8'h00, 8'hFF, 0);
		send_tuple(8'h00, 8'h00, 8'hFF, 8'h00, 0);
		send_tuple(8'h00, 8'hFF, 8'h00, 8'hFF, 0);
		send_tuple(8'hFF, 8'h00, 8'h07, 8'h00, 0);
		send_tuple(8'hFF, 8'h00, 8'h07, 8'hAA, 0);
		send_tuple(8'hFE, 8'h09, 8'h09, 8'h55, 0);
		send_tuple(8'hFF, 8'hFF, 8'hFF, 8'h00, 1);
		// leading axis falls while a later one rises, then ordered steps at axes 1 and 2
		send_tuple(8'h05, 8'h05, 8'h05, 8'h01, 0);
		send_tuple(8'h04, 8'h09, 8'h00, 8'h02, 0);
		send_tuple(8'h04, 8'h09, 8'h00, 8'h03, 1);
		send_tuple(8'h01, 8'h01, 8'h01, 8'h00, 0);
		send_tuple(8'h01, 8'h02, 8'h00, 8'h00, 1);
		send_tuple(8'h03, 8'h03, 8'h03, 8'h00, 0);
		send_tuple(8'h03, 8'h03, 8'h04, 8'h00, 1);

		sent = 0;
		seq_no = 0;
		while (sent < RANDOM_TUPLES) begin
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			len = $urandom_range(0, 5) == 0 ? $urandom_range(9, 30) : $urandom_range(1, 8);
			if (seq_no == 1) begin
				tx_idle = 0;
				len = 16;
				holds_asked++;
			end
			if (seq_no == 3)
				wait_drained();
			send_sequence(len);
			sent += len;
			seq_no++;
		end

		tx_idle = 1;
		rx_idle = 1;
		repeat (4)
			send_sequence($urandom_range(2, 8));

		in_valid <= 1'b0;
		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && writes_pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 2000000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
